// ----- sv/b64d_pkg.sv -----
// Shared types, constants and the alphabet lookup for the Base64 stream decoder.
package b64d_pkg;

  // Character codes of the decoding alphabet.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // Result queue geometry and the largest number of results one character makes.
  localparam int unsigned BURST_MAX   = 3;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        message_done;
    logic [15:0] total_length;
  } b64d_out_t;

  // Results of one character, handed from the decoder to the result queue.
  typedef struct packed {
    logic [1:0]                    count;
    b64d_out_t [BURST_MAX-1:0]     res;
  } b64d_burst_t;

  // Returns {in_alphabet, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      r = {1'b1, 6'(c - CHAR_UPPER_A)};
    end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      r = {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
    end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      r = {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

// ----- sv/b64d_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transfer.
interface b64d_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- sv/b64d_decode.sv -----
// Input register and single-pass sextet decode that turns one character into up to three results.
module b64d_decode #(
  parameter int unsigned MAX_OUTPUT_BYTES = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  b64d_pkg::b64d_in_t   in_item,
  output logic                 in_ready,
  input  logic                 room,
  output b64d_pkg::b64d_burst_t burst
);
  import b64d_pkg::*;

  localparam logic [15:0] COUNT_CAP =
    (MAX_OUTPUT_BYTES > 65535) ? 16'hFFFF : 16'(MAX_OUTPUT_BYTES);

  logic        valid_r, valid_nxt;
  b64d_in_t    item_r;
  logic [1:0]  fill_r, fill_nxt;
  logic        stopped_r, stopped_nxt;
  logic [15:0] count_r, count_nxt;
  logic [5:0]  sext_r [3];

  logic        step;
  logic [6:0]  sx;
  logic [5:0]  s [4];
  logic [7:0]  b [3];
  logic [1:0]  n;
  logic        eom;
  logic        store;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] k);
    logic [16:0] sum;
    sum = {1'b0, a} + {15'd0, k};
    return (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[15:0];
  endfunction

  assign step     = valid_r && room;
  assign in_ready = !valid_r || room;

  always_comb begin
    sx    = sextet_of(item_r.char_code);
    eom   = item_r.end_of_message;
    store = 1'b0;

    for (int i = 0; i < 3; i++) begin
      if (2'(i) < fill_r) begin
        s[i] = sext_r[i];
      end else if (2'(i) == fill_r && sx[6]) begin
        s[i] = sx[5:0];
      end else begin
        s[i] = '0;
      end
    end
    s[3] = (fill_r == 2'd3 && sx[6]) ? sx[5:0] : 6'd0;

    b[0] = {s[0], s[1][5:4]};
    b[1] = {s[1][3:0], s[2][5:2]};
    b[2] = {s[2][1:0], s[3]};

    n           = 2'd0;
    fill_nxt    = fill_r;
    stopped_nxt = stopped_r;
    if (!stopped_r) begin
      if (sx[6]) begin
        if (fill_r == 2'd3) begin
          n        = 2'd3;
          fill_nxt = 2'd0;
        end else begin
          store    = 1'b1;
          fill_nxt = fill_r + 2'd1;
          if (eom) begin
            n = fill_r;
          end
        end
      end else begin
        if (fill_r > 2'd1) begin
          n = fill_r - 2'd1;
        end
        fill_nxt    = 2'd0;
        stopped_nxt = 1'b1;
      end
    end

    count_nxt = sat_add(count_r, n);
    if (eom) begin
      fill_nxt    = 2'd0;
      stopped_nxt = 1'b0;
      count_nxt   = '0;
    end

    for (int j = 0; j < BURST_MAX; j++) begin
      burst.res[j].out_byte     = b[j];
      burst.res[j].byte_present = 1'b1;
      burst.res[j].message_done = eom && (n == 2'(j + 1));
      burst.res[j].total_length = sat_add(count_r, 2'(j + 1));
    end
    burst.count = n;
    if (eom && n == 2'd0) begin
      // Bare terminator: no byte, just the final count.
      burst.count                = 2'd1;
      burst.res[0].out_byte      = '0;
      burst.res[0].byte_present  = 1'b0;
      burst.res[0].message_done  = 1'b1;
      burst.res[0].total_length  = count_r;
    end
    if (!step) begin
      burst.count = 2'd0;
    end

    valid_nxt = in_valid && in_ready ? 1'b1 : (step ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      fill_r    <= '0;
      stopped_r <= 1'b0;
      count_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (step) begin
        fill_r    <= fill_nxt;
        stopped_r <= stopped_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (step && store) begin
      sext_r[fill_r] <= sx[5:0];
    end
  end

endmodule

// ----- sv/b64d_result_queue.sv -----
// Result queue that takes a burst of up to three results per cycle and releases one per transfer.
module b64d_result_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64d_pkg::b64d_burst_t burst,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output b64d_pkg::b64d_out_t   out_item
);
  import b64d_pkg::*;

  b64d_out_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // Room for a full burst, not counting a transfer in the same cycle.
  assign room      = (cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH - BURST_MAX));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_PTR_W'(burst.count);
    rd_ptr_nxt = rd_ptr_r + QUEUE_PTR_W'(pop);
    cnt_nxt    = cnt_r + QUEUE_CNT_W'(burst.count) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < BURST_MAX; j++) begin
      if (2'(j) < burst.count) begin
        entry_r[wr_ptr_r + QUEUE_PTR_W'(j)] <= burst.res[j];
      end
    end
  end

endmodule

// ----- sv/base64_stream_decoder.sv -----
// Top level of the streaming Base64 decoder.
//
// The input channel in_ch carries one ASCII character per transfer together
// with an end-of-message flag. The output channel out_ch carries one decoded
// byte per transfer, or a bare terminator when a message ends without a byte.
// The last result of every message has message_done set and total_length
// holds the saturating count of bytes decoded in that message.
// A character is captured in an input register and decoded from there,
// once the queue has room, into zero to three results, which are written
// together into an eight-entry result queue. The first result of a
// character reaches out_ch through the input register and the queue.
// The decoder takes one character per cycle as long as the queue has room
// for a full group of three results; a stalled receiver fills the queue,
// after which in_ch.ready drops until the receiver takes results again.
// Sustained throughput is one character per cycle, bounded by one result
// per cycle on out_ch.
// Synchronous reset clears the input register's valid flag, the group fill,
// the stop flag, the byte count and the queue; no result is offered after reset.
module base64_stream_decoder #(
  parameter int unsigned MAX_OUTPUT_BYTES = 65535
) (
  input  logic          clk,
  input  logic          rst_n,
  b64d_stream_if.sink   in_ch,
  b64d_stream_if.source out_ch
);
  import b64d_pkg::*;

  b64d_burst_t burst;
  logic        room;
  b64d_out_t   out_item;
  b64d_in_t    in_item;

  assign in_item = in_ch.payload;

  // Decode stage: holds one character and the partial group state.
  b64d_decode #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .room     (room),
    .burst    (burst)
  );

  // Result queue: absorbs bursts of up to three results and decouples a stalled receiver.
  b64d_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.payload = out_item;

endmodule

// ----- sv/b64d_checker.sv -----
// Port-level checker for the Base64 stream decoder, bound to the top level.
module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input b64d_pkg::b64d_out_t out_item
);
  import b64d_pkg::*;

  a_idle_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  a_terminator_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_present |->
      out_item.message_done && out_item.out_byte == 8'd0)
    else $error("byte-less result that is not a clean terminator");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.byte_present |-> out_item.total_length != 16'd0)
    else $error("decoded byte with zero total length");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);
